>>> sv/bounded_dfs_path_enumerator_macros.svh
// ----------------------------------------------------------------------------
// bounded dfs path enumerator assertion macros
// shared concurrent assertion forms used by the top level
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DFS_PATH_ENUMERATOR_MACROS_SVH
`define BOUNDED_DFS_PATH_ENUMERATOR_MACROS_SVH

// implication checked every clock outside reset
`define BDPE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication checked outside reset
`define BDPE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/bdpe_pkg.sv
// ----------------------------------------------------------------------------
// bdpe_pkg
// types and constants of the bounded dfs path enumerator
// ----------------------------------------------------------------------------
package bdpe_pkg;

   localparam int NODE_COUNT_DEF     = 4096;
   localparam int EDGE_COUNT_DEF     = 16384;
   localparam int DEPTH_LIMIT_DEF    = 8;
   localparam int RELATION_COUNT_DEF = 1024;

   localparam int PATHS_MAX      = 3;
   localparam int MIN_REPORT_LEN = 2;

   localparam int SLOT_W = 15;
   localparam int NODE_W = 12;
   localparam int REL_W  = 10;
   localparam int MD_W   = 4;
   localparam int CAP_W  = 16;

   localparam logic [1:0] ACT_OFFSET = 2'd0;
   localparam logic [1:0] ACT_EDGE   = 2'd1;
   localparam logic [1:0] ACT_QUERY  = 2'd2;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   localparam logic CSR_DEPTH_CAP  = 1'b0;
   localparam logic CSR_BRANCH_CAP = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,     // offset[src] back, read offset[src+1]
      ST_START2,
      ST_LOOK,      // decide at top frame, issue edge read
      ST_EDGE,      // edge data back, read flag of dest
      ST_FLAG,      // flag back, decide
      ST_PUSH,      // offset[dest] back, read offset[dest+1]
      ST_PUSH2,
      ST_EMIT,      // emit relations
      ST_UNWIND,
      ST_DONE,
      ST_CLEAR
   } state_type;

endpackage

>>> sv/bdpe_ram.sv
// ----------------------------------------------------------------------------
// bdpe_ram
// generic single port write, single port read memory with registered read
// ----------------------------------------------------------------------------
module bdpe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> sv/bounded_dfs_path_enumerator.sv
// ----------------------------------------------------------------------------
// bounded_dfs_path_enumerator
// Bounded depth-first enumerator of simple paths. Offset and edge writes are
// taken in idle. A query sets up the source frame in start and start2,
// inspects each edge through look, edge and flag (edge read, on-path read,
// decision), enters a node through push and push2, leaves each exhausted
// frame through look and unwind, emits one word per reported relation,
// unwinds each frame still on the stack after the third path and ends with
// the done word; result stalls hold the emit and done steps. Reads of the
// offset, edge and on-path memories are registered. After reset the on-path
// memory is swept clear, one entry per cycle, before the first item is taken.
// Up to three paths of two or more relations are reported, one word per
// relation, and every query ends with a done word (tlast high).
// ----------------------------------------------------------------------------
`include "bounded_dfs_path_enumerator_macros.svh"

module bounded_dfs_path_enumerator #(
   parameter int NODE_COUNT  = bdpe_pkg::NODE_COUNT_DEF,
   parameter int EDGE_COUNT  = bdpe_pkg::EDGE_COUNT_DEF,
   parameter int DEPTH_LIMIT = bdpe_pkg::DEPTH_LIMIT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // slot[14:0], offset_value[29:15], node_a[41:30], node_b[53:42],
   // relation_in[63:54]
   input  logic [63:0] req_tdata,
   // action[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // path_number[1:0], position[4:2], relation_out[14:5], path_end[15]
   output logic [15:0] rsp_tdata,
   // kind[0]
   output logic        rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   localparam int NW  = $clog2(NODE_COUNT);
   localparam int OW  = $clog2(NODE_COUNT + 1);
   localparam int EW  = $clog2(EDGE_COUNT);
   localparam int EW1 = $clog2(EDGE_COUNT + 1);
   localparam int FD  = DEPTH_LIMIT + 1;
   localparam int TW  = $clog2(FD);
   localparam int DW  = $clog2(DEPTH_LIMIT + 1);
   localparam int SW  = bdpe_pkg::SLOT_W;
   localparam int RW  = bdpe_pkg::REL_W;
   localparam int EDW = bdpe_pkg::NODE_W + RW;
   localparam int CW  = bdpe_pkg::CAP_W;

   // request fields
   logic [SW-1:0]               f_slot;
   logic [SW-1:0]               f_offv;
   logic [bdpe_pkg::NODE_W-1:0] f_na, f_nb;
   logic [RW-1:0]               f_rel;
   assign f_slot = req_tdata[14:0];
   assign f_offv = req_tdata[29:15];
   assign f_na   = req_tdata[41:30];
   assign f_nb   = req_tdata[53:42];
   assign f_rel  = req_tdata[63:54];

   bdpe_pkg::state_type state_ff, state_in;

   logic [bdpe_pkg::MD_W-1:0] md_ff;
   logic [CW-1:0]             cap_ff;
   logic [bdpe_pkg::NODE_W-1:0] src_ff, src_in, dst_ff, dst_in;
   logic [TW-1:0]             top_ff, top_in;
   logic [NW:0]               clr_ff, clr_in;
   logic [1:0]                pf_ff, pf_in;
   logic [DW-1:0]             k_ff, k_in;
   logic [EDW-1:0]            edge_q;
   logic [NW-1:0]             dest_ff, dest_in;
   logic [RW-1:0]             rel_ff, rel_in;
   logic                      dest_ok_ff, dest_ok_in;

   logic [NW-1:0]  fnode [FD];
   logic [EW1-1:0] fcur  [FD];
   logic [EW1-1:0] fend  [FD];
   logic [CW-1:0]  finsp [FD];
   logic [RW-1:0]  rstk  [DEPTH_LIMIT];

   // output register
   logic        ov_ff;
   logic [15:0] od_ff;
   logic        ou_ff, ol_ff;
   logic        emit;
   logic [15:0] emit_d;
   logic        emit_u, emit_l;
   logic        out_free;
   assign out_free   = !ov_ff || rsp_tready;
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;
   assign rsp_tuser  = ou_ff;
   assign rsp_tlast  = ol_ff;

   logic req_acc;
   assign req_tready = (state_ff == bdpe_pkg::ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // memories
   logic            off_we;
   logic [OW-1:0]   off_ra;
   logic [SW-1:0]   off_rd;
   logic            edg_we;
   logic [EW-1:0]   edg_ra;
   logic            flg_we;
   logic [NW-1:0]   flg_wa, flg_ra;
   logic            flg_wd;
   logic [0:0]      flg_rd;

   assign off_we = req_acc && req_tuser == bdpe_pkg::ACT_OFFSET &&
                   {17'd0, f_slot} <= 32'(NODE_COUNT);
   assign edg_we = req_acc && req_tuser == bdpe_pkg::ACT_EDGE &&
                   {17'd0, f_slot} < 32'(EDGE_COUNT);

   bdpe_ram #(.WIDTH(SW), .DEPTH(NODE_COUNT + 1)) u_off (
      .clock, .wr_en(off_we), .wr_addr(OW'(f_slot)), .wr_data(f_offv),
      .rd_addr(off_ra), .rd_data(off_rd));
   bdpe_ram #(.WIDTH(EDW), .DEPTH(EDGE_COUNT)) u_edge (
      .clock, .wr_en(edg_we), .wr_addr(EW'(f_slot)), .wr_data({f_na, f_rel}),
      .rd_addr(edg_ra), .rd_data(edge_q));
   bdpe_ram #(.WIDTH(1), .DEPTH(NODE_COUNT)) u_flag (
      .clock, .wr_en(flg_we), .wr_addr(flg_wa), .wr_data(flg_wd),
      .rd_addr(flg_ra), .rd_data(flg_rd));

   // effective depth limit
   logic [DW-1:0] md_eff;
   assign md_eff = ({28'd0, md_ff} > 32'(DEPTH_LIMIT)) ? DW'(DEPTH_LIMIT)
                                                       : DW'(md_ff);

   logic [TW-1:0] top_nx;
   assign top_nx = top_ff + TW'(1);
   logic [DW-1:0] d_cur;
   assign d_cur = DW'(top_ff) + DW'(1);

   // frame of the current top
   logic [EW1-1:0] cur_t, end_t;
   logic [CW-1:0]  insp_t;
   logic           frame_done;
   assign cur_t  = fcur[top_ff];
   assign end_t  = fend[top_ff];
   assign insp_t = finsp[top_ff];
   assign frame_done = cur_t >= end_t || {{(32-EW1){1'b0}}, cur_t} >= 32'(EDGE_COUNT)
                       || insp_t >= cap_ff;

   // frame update controls
   logic            fr_init;    // write fnode/finsp at top_in
   logic [TW-1:0]   fr_idx;
   logic [NW-1:0]   fr_node;
   logic            fr_setcur, fr_setend, fr_step;
   logic [EW1-1:0]  fr_val;
   logic            rs_we;

   always_comb begin
      state_in   = state_ff;
      case (state_ff)
         bdpe_pkg::ST_CLEAR:
            if (clr_ff == (NW+1)'(NODE_COUNT - 1)) state_in = bdpe_pkg::ST_IDLE;
         bdpe_pkg::ST_IDLE:
            if (req_acc && req_tuser == bdpe_pkg::ACT_QUERY) begin
               if ({20'd0, f_na} >= 32'(NODE_COUNT) || f_na == f_nb || md_eff == '0)
                  state_in = bdpe_pkg::ST_DONE;
               else
                  state_in = bdpe_pkg::ST_START;
            end
         bdpe_pkg::ST_START:  state_in = bdpe_pkg::ST_START2;
         bdpe_pkg::ST_START2: state_in = bdpe_pkg::ST_LOOK;
         bdpe_pkg::ST_LOOK:
            state_in = frame_done ? bdpe_pkg::ST_UNWIND : bdpe_pkg::ST_EDGE;
         bdpe_pkg::ST_EDGE:   state_in = bdpe_pkg::ST_FLAG;
         bdpe_pkg::ST_FLAG:
            if (!dest_ok_ff || flg_rd[0]) state_in = bdpe_pkg::ST_LOOK;
            else if ({{(32-NW){1'b0}}, dest_ff} == {20'd0, dst_ff}) begin
               state_in = (d_cur >= DW'(bdpe_pkg::MIN_REPORT_LEN)) ?
                          bdpe_pkg::ST_EMIT : bdpe_pkg::ST_LOOK;
            end else if (d_cur >= md_eff) state_in = bdpe_pkg::ST_LOOK;
            else state_in = bdpe_pkg::ST_PUSH;
         bdpe_pkg::ST_PUSH:  state_in = bdpe_pkg::ST_PUSH2;
         bdpe_pkg::ST_PUSH2: state_in = bdpe_pkg::ST_LOOK;
         bdpe_pkg::ST_EMIT:
            if (out_free && k_ff == d_cur - DW'(1)) begin
               state_in = (pf_ff == 2'(bdpe_pkg::PATHS_MAX - 1)) ?
                          bdpe_pkg::ST_UNWIND : bdpe_pkg::ST_LOOK;
            end
         bdpe_pkg::ST_UNWIND:
            if (top_ff == '0) state_in = bdpe_pkg::ST_DONE;
            else if (pf_ff != 2'(bdpe_pkg::PATHS_MAX)) state_in = bdpe_pkg::ST_LOOK;
         bdpe_pkg::ST_DONE:
            if (out_free) state_in = bdpe_pkg::ST_IDLE;
         default: state_in = bdpe_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      src_in = src_ff; dst_in = dst_ff; top_in = top_ff; clr_in = clr_ff;
      pf_in = pf_ff; k_in = k_ff;
      dest_in = dest_ff; rel_in = rel_ff; dest_ok_in = dest_ok_ff;
      off_ra = OW'(0); edg_ra = cur_t[EW-1:0]; flg_ra = dest_ff;
      flg_we = 1'b0; flg_wa = fnode[top_ff]; flg_wd = 1'b0;
      fr_init = 1'b0; fr_idx = top_ff; fr_node = '0;
      fr_setcur = 1'b0; fr_setend = 1'b0; fr_step = 1'b0; fr_val = '0;
      rs_we = 1'b0;
      emit = 1'b0; emit_d = '0; emit_u = 1'b0; emit_l = 1'b0;
      case (state_ff)
         bdpe_pkg::ST_CLEAR: begin
            flg_we = 1'b1; flg_wa = clr_ff[NW-1:0]; clr_in = clr_ff + (NW+1)'(1);
         end
         bdpe_pkg::ST_IDLE: begin
            src_in = f_na; dst_in = f_nb; pf_in = '0; top_in = '0;
            off_ra = OW'(f_na);
         end
         bdpe_pkg::ST_START: begin
            off_ra = OW'(src_ff) + OW'(1);
            flg_we = 1'b1; flg_wa = NW'(src_ff); flg_wd = 1'b1;
            fr_init = 1'b1; fr_idx = '0; fr_node = NW'(src_ff);
            fr_setcur = 1'b1; fr_val = EW1'(off_rd);
         end
         bdpe_pkg::ST_START2: begin
            fr_setend = 1'b1; fr_val = EW1'(off_rd);
         end
         bdpe_pkg::ST_LOOK: begin
            edg_ra = cur_t[EW-1:0];
            if (!frame_done) fr_step = 1'b1;
         end
         bdpe_pkg::ST_EDGE: begin
            dest_ok_in = {{(32-bdpe_pkg::NODE_W){1'b0}}, edge_q[EDW-1:RW]} <
                         32'(NODE_COUNT);
            dest_in = NW'(edge_q[EDW-1:RW]);
            rel_in = edge_q[RW-1:0];
            flg_ra = NW'(edge_q[EDW-1:RW]);
         end
         bdpe_pkg::ST_FLAG: begin
            k_in = '0;
            if (dest_ok_ff && !flg_rd[0]) begin
               rs_we = 1'b1;
               if (!({{(32-NW){1'b0}}, dest_ff} == {20'd0, dst_ff}) && d_cur < md_eff)
               begin
                  off_ra = OW'(dest_ff);
                  flg_we = 1'b1; flg_wa = dest_ff; flg_wd = 1'b1;
               end
            end
         end
         bdpe_pkg::ST_PUSH: begin
            off_ra = OW'(dest_ff) + OW'(1);
            top_in = top_nx;
            fr_init = 1'b1; fr_idx = top_nx; fr_node = dest_ff;
            fr_setcur = 1'b1; fr_val = EW1'(off_rd);
         end
         bdpe_pkg::ST_PUSH2: begin
            fr_setend = 1'b1; fr_val = EW1'(off_rd);
         end
         bdpe_pkg::ST_EMIT: begin
            emit = 1'b1;
            emit_d = {k_ff == d_cur - DW'(1), rstk[k_ff[$clog2(DEPTH_LIMIT)-1:0]],
                      3'(k_ff), pf_ff};
            if (out_free) begin
               k_in = k_ff + DW'(1);
               if (k_ff == d_cur - DW'(1)) pf_in = pf_ff + 2'd1;
            end
         end
         bdpe_pkg::ST_UNWIND: begin
            flg_we = 1'b1; flg_wa = fnode[top_ff];
            if (top_ff != '0) top_in = top_ff - TW'(1);
         end
         bdpe_pkg::ST_DONE: begin
            emit = 1'b1; emit_u = 1'b1; emit_l = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bdpe_pkg::ST_CLEAR;
         md_ff    <= 4'd7;
         cap_ff   <= 16'd200;
         clr_ff   <= '0;
         top_ff   <= '0;
         pf_ff    <= '0;
         k_ff     <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         top_ff   <= top_in;
         pf_ff    <= pf_in;
         k_ff     <= k_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == bdpe_pkg::CSR_DEPTH_CAP) md_ff <= csr_data[3:0];
            else cap_ff <= csr_data;
         end
         if (emit && out_free) ov_ff <= 1'b1;
         else if (rsp_tready) ov_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      src_ff <= src_in; dst_ff <= dst_in;
      dest_ff <= dest_in; rel_ff <= rel_in; dest_ok_ff <= dest_ok_in;
      if (emit && out_free) begin
         od_ff <= emit_d; ou_ff <= emit_u; ol_ff <= emit_l;
      end
      if (fr_init) begin
         fnode[fr_idx] <= fr_node;
         finsp[fr_idx] <= '0;
      end
      if (fr_setcur) fcur[fr_idx] <= fr_val;
      if (fr_setend) fend[top_ff] <= fr_val;
      if (fr_step) begin
         fcur[top_ff]  <= cur_t + EW1'(1);
         finsp[top_ff] <= insp_t + CW'(1);
      end
      if (rs_we) rstk[top_ff[$clog2(DEPTH_LIMIT)-1:0]] <= rel_ff;
   end

   `BDPE_ASSERT_IMP(a_ready_idle, clock, reset, req_tready,
      state_ff == bdpe_pkg::ST_IDLE, "input taken outside idle")
   `BDPE_ASSERT_IMP(a_paths_bound, clock, reset, 1'b1,
      pf_ff <= 2'(bdpe_pkg::PATHS_MAX), "too many paths")
   `BDPE_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

endmodule
